@@ sv/stt_pkg.sv @@
// Shared types, kind codes and helpers for the source text tokenizer.
// No dependencies; every other file imports this package.
package stt_pkg;

  localparam int unsigned TextLimit = 1048576;
  localparam logic [19:0] OffMax    = 20'(TextLimit - 1);
  localparam logic [20:0] CntMax    = 21'(TextLimit);
  localparam int unsigned QDepth    = 8;
  localparam int unsigned QPtrW     = $clog2(QDepth);

  typedef enum logic [3:0] {
    MD_IDLE, MD_SLASH, MD_COMMENT, MD_IDENT, MD_INT, MD_INT_DOT, MD_FLOAT,
    MD_STR, MD_STR_ESC, MD_MINUS, MD_BANG, MD_EQUAL, MD_LESS, MD_GREATER,
    MD_AMP, MD_BAR
  } mode_e;

  localparam logic [5:0] KD_EOF = 6'd0, KD_BAD = 6'd1, KD_IDENT = 6'd2;
  localparam logic [5:0] KD_INT = 6'd3, KD_FLOAT = 6'd4, KD_STR = 6'd5;
  localparam logic [5:0] KD_PLUS = 6'd27, KD_MINUS = 6'd28, KD_STAR = 6'd29;
  localparam logic [5:0] KD_SLASH = 6'd30, KD_PERCENT = 6'd31, KD_BANG = 6'd32;
  localparam logic [5:0] KD_ASSIGN = 6'd33, KD_EQ = 6'd34, KD_NE = 6'd35;
  localparam logic [5:0] KD_LT = 6'd36, KD_LE = 6'd37, KD_GT = 6'd38;
  localparam logic [5:0] KD_GE = 6'd39, KD_ANDAND = 6'd40, KD_OROR = 6'd41;
  localparam logic [5:0] KD_ARROW = 6'd42, KD_LPAREN = 6'd43, KD_RPAREN = 6'd44;
  localparam logic [5:0] KD_LBRACE = 6'd45, KD_RBRACE = 6'd46, KD_COMMA = 6'd47;
  localparam logic [5:0] KD_COLON = 6'd48, KD_SEMI = 6'd49;

  typedef struct packed {
    logic        fin;
    logic [20:0] col;
    logic [20:0] line;
    logic [20:0] len;
    logic [19:0] off;
    logic [5:0]  kind;
  } tok_t;

  typedef struct packed {
    logic [1:0] cnt;
    tok_t [2:0] tok;
  } push_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [19:0] sat_off_inc(input logic [19:0] x);
    return (x == OffMax) ? x : x + 20'd1;
  endfunction

  function automatic logic [20:0] sat_cnt_add(input logic [20:0] a, input logic [20:0] b);
    logic [21:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, CntMax}) ? CntMax : s[20:0];
  endfunction

  function automatic logic [19:0] sat_off_add(input logic [19:0] a, input logic [20:0] b);
    logic [21:0] s;
    s = {2'b0, a} + {1'b0, b};
    return (s > {2'b0, OffMax}) ? OffMax : s[19:0];
  endfunction

  // Keyword lookup; window holds the first bytes, first char lowest.
  function automatic logic [5:0] word_kind(input logic [63:0] w, input logic [20:0] len);
    logic [5:0] k;
    k = KD_IDENT;
    if (len <= 21'd8) begin
      unique case (w)
        64'h6e66:             k = 6'd6;
        64'h6669:             k = 6'd10;
        64'h74656c:           k = 6'd8;
        64'h696e6177756d:     k = 6'd8;
        64'h65736c65:         k = 6'd11;
        64'h65757274:         k = 6'd16;
        64'h64696f76:         k = 6'd18;
        64'h746e69:           k = 6'd19;
        64'h61626d61:         k = 6'd23;
        64'h74736e6f63:       k = 6'd9;
        64'h746f7263:         k = 6'd9;
        64'h656c696877:       k = 6'd12;
        64'h726f66:           k = 6'd13;
        64'h6b61657262:       k = 6'd14;
        64'h65756e69746e6f63: k = 6'd15;
        64'h65736c6166:       k = 6'd17;
        64'h74616f6c66:       k = 6'd20;
        64'h6964737572:       k = 6'd24;
        64'h64617566:         k = 6'd25;
        64'h74756d69:         k = 6'd26;
        64'h6e7275746572:     k = 6'd7;
        64'h676e69727473:     k = 6'd22;
        64'h6c6f6f62:         k = 6'd21;
        default:              k = KD_IDENT;
      endcase
    end
    return k;
  endfunction

endpackage

@@ sv/stt_front.sv @@
// Scanner front end: accepts one byte per beat, runs the lexer state and
// pushes up to three finished tokens per beat. Depends on stt_pkg.
module stt_front import stt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  input  logic        space_ok_i,
  output push_t       push_o
);

  mode_e       mode_q, mode_d;
  logic [63:0] win_q, win_d;
  logic [20:0] len_q, len_d;
  logic [19:0] soff_q, soff_d;
  logic [20:0] sline_q, sline_d;
  logic [20:0] scol_q, scol_d;
  logic [19:0] pos_q, pos_d;
  logic [20:0] line_q, line_d;
  logic [20:0] col_q, col_d;

  logic accept;
  assign in_ready_o = space_ok_i;
  assign accept     = in_valid_i && space_ok_i;

  always_comb begin
    tok_t       t [3];
    logic [1:0] n;
    logic       go_idle, move;
    logic [7:0] c;
    logic [7:0] sec;
    logic [5:0] one, two, single;
    tok_t       pend;

    c = in_byte_i;
    for (int i = 0; i < 3; i++) t[i] = '0;
    n = 2'd0;
    go_idle = 1'b0;
    move = 1'b0;
    single = KD_BAD;
    mode_d = mode_q; win_d = win_q; len_d = len_q;
    soff_d = soff_q; sline_d = sline_q; scol_d = scol_q;
    pos_d = pos_q; line_d = line_q; col_d = col_q;

    pend = '{fin: 1'b0, col: scol_q, line: sline_q, len: len_q, off: soff_q, kind: KD_BAD};

    unique case (mode_q)
      MD_MINUS:   begin sec = ">"; one = KD_MINUS;  two = KD_ARROW;  end
      MD_BANG:    begin sec = "="; one = KD_BANG;   two = KD_NE;     end
      MD_EQUAL:   begin sec = "="; one = KD_ASSIGN; two = KD_EQ;     end
      MD_LESS:    begin sec = "="; one = KD_LT;     two = KD_LE;     end
      MD_GREATER: begin sec = "="; one = KD_GT;     two = KD_GE;     end
      MD_AMP:     begin sec = "&"; one = KD_BAD;    two = KD_ANDAND; end
      default:    begin sec = "|"; one = KD_BAD;    two = KD_OROR;   end
    endcase

    if (in_last_i || c == 8'd0) begin
      // flush pending token, then EOF, then back to reset state
      unique case (mode_q)
        MD_IDLE, MD_COMMENT: ;
        MD_SLASH: begin t[n] = pend; t[n].kind = KD_SLASH; n++; end
        MD_IDENT: begin t[n] = pend; t[n].kind = word_kind(win_q, len_q); n++; end
        MD_INT:   begin t[n] = pend; t[n].kind = KD_INT; n++; end
        MD_INT_DOT: begin
          t[n] = pend; t[n].kind = KD_INT; n++;
          t[n] = '{fin: 1'b0, col: sat_cnt_add(scol_q, len_q), line: sline_q,
                   len: 21'd1, off: sat_off_add(soff_q, len_q), kind: KD_BAD};
          n++;
        end
        MD_FLOAT: begin t[n] = pend; t[n].kind = KD_FLOAT; n++; end
        MD_STR, MD_STR_ESC: begin t[n] = pend; t[n].kind = KD_BAD; n++; end
        default: begin t[n] = pend; t[n].kind = one; n++; end
      endcase
      t[n] = '{fin: 1'b1, col: col_q, line: line_q, len: 21'd0, off: pos_q, kind: KD_EOF};
      n++;
      mode_d = MD_IDLE; win_d = '0; len_d = '0;
      soff_d = '0; sline_d = 21'd1; scol_d = 21'd1;
      pos_d = '0; line_d = 21'd1; col_d = 21'd1;
    end else begin
      unique case (mode_q)
        MD_IDLE: go_idle = 1'b1;
        MD_SLASH: begin
          if (c == "/") begin
            mode_d = MD_COMMENT; move = 1'b1;
          end else begin
            t[n] = pend; t[n].kind = KD_SLASH; n++; go_idle = 1'b1;
          end
        end
        MD_COMMENT: begin
          if (c == 8'h0a) mode_d = MD_IDLE;
          move = 1'b1;
        end
        MD_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            if (len_q < 21'd8) win_d = win_q | (64'(c) << {len_q[2:0], 3'b000});
            len_d = sat_cnt_add(len_q, 21'd1);
            move = 1'b1;
          end else begin
            t[n] = pend; t[n].kind = word_kind(win_q, len_q); n++; go_idle = 1'b1;
          end
        end
        MD_INT: begin
          if (is_digit(c)) begin
            len_d = sat_cnt_add(len_q, 21'd1); move = 1'b1;
          end else if (c == ".") begin
            mode_d = MD_INT_DOT; move = 1'b1;
          end else begin
            t[n] = pend; t[n].kind = KD_INT; n++; go_idle = 1'b1;
          end
        end
        MD_INT_DOT: begin
          if (is_digit(c)) begin
            len_d = sat_cnt_add(len_q, 21'd2); mode_d = MD_FLOAT; move = 1'b1;
          end else begin
            t[n] = pend; t[n].kind = KD_INT; n++;
            t[n] = '{fin: 1'b0, col: sat_cnt_add(scol_q, len_q), line: sline_q,
                     len: 21'd1, off: sat_off_add(soff_q, len_q), kind: KD_BAD};
            n++;
            go_idle = 1'b1;
          end
        end
        MD_FLOAT: begin
          if (is_digit(c)) begin
            len_d = sat_cnt_add(len_q, 21'd1); move = 1'b1;
          end else begin
            t[n] = pend; t[n].kind = KD_FLOAT; n++; go_idle = 1'b1;
          end
        end
        MD_STR: begin
          len_d = sat_cnt_add(len_q, 21'd1);
          move = 1'b1;
          if (c == 8'h22) begin
            t[n] = pend; t[n].len = len_d; t[n].kind = KD_STR; n++;
            mode_d = MD_IDLE;
          end else if (c == 8'h5c) begin
            mode_d = MD_STR_ESC;
          end
        end
        MD_STR_ESC: begin
          len_d = sat_cnt_add(len_q, 21'd1); move = 1'b1; mode_d = MD_STR;
        end
        default: begin
          if (c == sec) begin
            len_d = 21'd2;
            t[n] = pend; t[n].len = 21'd2; t[n].kind = two; n++;
            mode_d = MD_IDLE; move = 1'b1;
          end else begin
            t[n] = pend; t[n].kind = one; n++; go_idle = 1'b1;
          end
        end
      endcase

      if (go_idle) begin
        mode_d = MD_IDLE;
        move = 1'b1;
        if (!(c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a)) begin
          soff_d = pos_q; sline_d = line_q; scol_d = col_q; len_d = 21'd1;
          if (is_alpha(c)) begin
            mode_d = MD_IDENT; win_d = 64'(c);
          end else if (is_digit(c)) begin
            mode_d = MD_INT;
          end else begin
            priority case (c)
              "/":   mode_d = MD_SLASH;
              8'h22: mode_d = MD_STR;
              "-":   mode_d = MD_MINUS;
              "!":   mode_d = MD_BANG;
              "=":   mode_d = MD_EQUAL;
              "<":   mode_d = MD_LESS;
              ">":   mode_d = MD_GREATER;
              "&":   mode_d = MD_AMP;
              "|":   mode_d = MD_BAR;
              "+":   single = KD_PLUS;
              "*":   single = KD_STAR;
              "%":   single = KD_PERCENT;
              "(":   single = KD_LPAREN;
              ")":   single = KD_RPAREN;
              "{":   single = KD_LBRACE;
              "}":   single = KD_RBRACE;
              ",":   single = KD_COMMA;
              ":":   single = KD_COLON;
              ";":   single = KD_SEMI;
              default: single = KD_BAD;
            endcase
            if (mode_d == MD_IDLE) begin
              t[n] = '{fin: 1'b0, col: col_q, line: line_q, len: 21'd1, off: pos_q,
                       kind: single};
              n++;
            end
          end
        end
      end

      if (move) begin
        pos_d = sat_off_inc(pos_q);
        if (c == 8'h0a) begin
          line_d = sat_cnt_add(line_q, 21'd1); col_d = 21'd1;
        end else begin
          col_d = sat_cnt_add(col_q, 21'd1);
        end
      end
    end

    push_o.cnt = accept ? n : 2'd0;
    for (int i = 0; i < 3; i++) push_o.tok[i] = t[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MD_IDLE; win_q <= '0; len_q <= '0;
      soff_q <= '0; sline_q <= 21'd1; scol_q <= 21'd1;
      pos_q <= '0; line_q <= 21'd1; col_q <= 21'd1;
    end else if (accept) begin
      mode_q <= mode_d; win_q <= win_d; len_q <= len_d;
      soff_q <= soff_d; sline_q <= sline_d; scol_q <= scol_d;
      pos_q <= pos_d; line_q <= line_d; col_q <= col_d;
    end
  end

endmodule

@@ sv/stt_queue.sv @@
// Token queue between scanner and output stage: up to three writes and
// one read per cycle. Depends on stt_pkg.
module stt_queue import stt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  space_ok_o,
  output logic  pop_valid_o,
  input  logic  pop_i,
  output tok_t  pop_tok_o
);

  tok_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q, cnt_d;
  logic             pop;

  assign space_ok_o  = cnt_q <= (QPtrW+1)'(QDepth - 3);
  assign pop_valid_o = cnt_q != '0;
  assign pop         = pop_i && pop_valid_o;
  assign pop_tok_o   = mem_q[rd_q];
  assign cnt_d = cnt_q + (QPtrW+1)'(push_i.cnt) - (QPtrW+1)'(pop);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push_i.cnt) mem_q[wr_q + QPtrW'(i)] <= push_i.tok[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPtrW'(push_i.cnt);
      rd_q  <= rd_q + QPtrW'(pop);
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ sv/stt_back.sv @@
// Output stage: holds one token in a register and presents it on the
// master stream. Depends on stt_pkg.
module stt_back import stt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  tok_valid_i,
  output logic  tok_pop_o,
  input  tok_t  tok_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output tok_t  out_tok_o
);

  logic valid_q;
  tok_t tok_q;

  assign tok_pop_o   = tok_valid_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign out_tok_o   = tok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_ready_i) begin
      valid_q <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_pop_o) tok_q <= tok_i;
  end

endmodule

@@ sv/source_text_tokenizer_top.sv @@
// Source text tokenizer top level: scanner, token queue, output stage.
// Depends on stt_pkg, stt_front, stt_queue, stt_back.
//
// Source text enters one byte per beat (tlast marks end of text, a zero
// byte does the same) and tokens leave one per beat with kind, start
// offset, length, line and column; the EOF token carries tlast. The
// scanner takes a byte every cycle as long as the eight-entry token queue
// has room for three more tokens, the most one byte can finish; the output
// side drains one token per cycle while the sink is ready, so input runs
// at one byte per cycle whenever tokens are taken as fast as they are made
// on average. A finished token goes via the queue to the output register.
// Offsets saturate at 2^20-1; lengths, lines and columns at 2^20.
module source_text_tokenizer_top import stt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] text_byte
  input  logic        s_axis_tlast_i,   // end_of_text
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [95:0] m_axis_tdata_o,   // [5:0] token_kind, [25:6] start_offset,
                                        // [46:26] token_length, [67:47] start_line,
                                        // [88:68] start_column, rest zero
  output logic        m_axis_tlast_o    // final_token
);

  push_t push;
  logic  space_ok, q_valid, q_pop;
  tok_t  q_tok, o_tok;

  stt_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .space_ok_i (space_ok),
    .push_o     (push)
  );

  stt_queue u_queue (
    .clk_i, .rst_ni,
    .push_i      (push),
    .space_ok_o  (space_ok),
    .pop_valid_o (q_valid),
    .pop_i       (q_pop),
    .pop_tok_o   (q_tok)
  );

  stt_back u_back (
    .clk_i, .rst_ni,
    .tok_valid_i (q_valid),
    .tok_pop_o   (q_pop),
    .tok_i       (q_tok),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_tok_o   (o_tok)
  );

  // token fields packed from the lowest bit up; fin goes out on tlast
  assign m_axis_tdata_o = {7'd0, o_tok.col, o_tok.line, o_tok.len, o_tok.off, o_tok.kind};
  assign m_axis_tlast_o = o_tok.fin;

endmodule
